// ----- design/lzss_pkg.sv -----
package lzss_pkg;

    localparam int WINDOW_SIZE_D   = 4096;
    localparam int MAX_MATCH_D     = 18;
    localparam int POSITION_BITS_D = 21;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [20:0] out_position;
        logic        end_of_image;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_TOKEN,
        S_FLUSH,
        S_PAD,
        S_HDR,
        S_RESET
    } t_state;

endpackage

// ----- design/lzss_window_compressor.sv -----
// A non-final byte goes to the lookahead; once it is full, the head byte starts a token,
//   whose search probes offsets 3..min(pos,4096) byte by byte, since the history memory
//   gives one byte per probe, read in S_SRCH_RD and compared in S_SRCH_CMP.
// Final byte: the lookahead drains the same way, then one cycle per flush, pad
//   and header byte plus output stalls. One transaction in flight at a time.
// Reset: i_rst_n synchronous, active low; history memory needs no clearing.
module lzss_window_compressor #(
    parameter int WINDOW_SIZE   = lzss_pkg::WINDOW_SIZE_D,
    parameter int MAX_MATCH     = lzss_pkg::MAX_MATCH_D,
    parameter int POSITION_BITS = lzss_pkg::POSITION_BITS_D
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lzss_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output lzss_pkg::t_out o_data
);
    import lzss_pkg::*;

    localparam int WB = $clog2(WINDOW_SIZE);
    localparam int OB = WB + 1;
    localparam int LB = $clog2(MAX_MATCH + 1);
    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] PMAX = {PB{1'b1}};

    // history memory
    logic [7:0] mem [WINDOW_SIZE];
    logic [7:0] r_rd;
    logic [WB-1:0] rd_addr;
    logic          wr_en;
    logic [WB-1:0] r_wr;
    logic [WB-1:0] wr_next;

    logic [7:0] r_la [MAX_MATCH];
    logic [LB-1:0] r_la_cnt, r_skip;
    logic [PB-1:0] r_in_pos, r_out_pos;
    logic [7:0] r_grp [16];
    logic [7:0] r_flags;
    logic [3:0] r_tok;
    logic [4:0] r_gbytes;
    logic [31:0] r_sum;
    logic        r_final;
    t_state      r_st, n_st;

    // search registers
    logic [OB-1:0] r_off, r_best_off;
    logic [LB-1:0] r_k, r_best, r_cap;
    logic [OB-1:0] r_maxoff;
    logic          r_may;
    // flush/pad/header counters
    logic [4:0] r_fi;
    logic [3:0] r_hi;
    logic [31:0] r_cks;

    logic [7:0] r_ob;
    logic [20:0] r_op;
    logic r_oe, r_ov;

    // candidate byte for probe (r_off, r_k)
    logic          from_hist;
    logic [7:0]    cand;
    logic [LB-1:0] la_idx;
    logic [WB:0]   hsum;
    assign from_hist = (OB'(r_k) < r_off);
    assign la_idx    = r_k - LB'(r_off);
    assign hsum      = (WB+1)'(r_wr) + (WB+1)'(r_k);
    // window index modulo the window size
    assign rd_addr   = (hsum >= r_off) ? WB'(hsum - r_off)
                                       : WB'(hsum + (WB+1)'(WINDOW_SIZE) - r_off);
    assign cand      = from_hist ? r_rd : r_la[la_idx];
    assign wr_next   = (r_wr == WB'(WINDOW_SIZE - 1)) ? '0 : r_wr + WB'(1);

    logic out_free;
    logic out_load;
    assign out_free = !r_ov || !i_stall;
    assign out_load = out_free && ((r_st == S_FLUSH) || (r_st == S_HDR) ||
                                   ((r_st == S_PAD) && (r_out_pos[1:0] != 2'b00)));
    assign o_valid  = r_ov;
    assign o_data   = '{out_byte: r_ob, out_position: r_op, end_of_image: r_oe};
    assign o_stall  = (r_st != S_IDLE);
    // history is written exactly when the head byte shifts out
    assign wr_en    = ((r_st == S_ADV) && (r_la_cnt != '0) && (r_skip != '0) &&
                       (r_final || r_la_cnt >= LB'(MAX_MATCH))) || (r_st == S_TOKEN);

    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_addr];
        if (wr_en) mem[r_wr] <= r_la[0];
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:     if (i_valid) n_st = S_ADV;
            S_ADV: begin
                if (!r_final && r_la_cnt < LB'(MAX_MATCH)) n_st = S_IDLE;
                else if (r_la_cnt == '0) n_st = S_FLUSH;
                else if (r_skip != '0) n_st = S_ADV;
                else n_st = S_SRCH_RD;
            end
            S_SRCH_RD: begin
                if (!r_may || r_off > r_maxoff) n_st = S_TOKEN;
                else n_st = S_SRCH_CMP;
            end
            S_SRCH_CMP: n_st = S_SRCH_RD;
            S_TOKEN:    n_st = (r_tok == 4'd7) ? S_FLUSH : S_ADV;
            S_FLUSH: begin
                if (out_free && r_fi == r_gbytes) n_st = (r_tok == 4'd8) ? S_ADV : S_PAD;
            end
            S_PAD:      if (out_free && r_out_pos[1:0] == 2'b00) n_st = S_HDR;
            S_HDR:      if (out_free && r_hi == 4'd7) n_st = S_RESET;
            S_RESET:    n_st = S_IDLE;
            default:    n_st = S_IDLE;
        endcase
    end

    // output valid: set on a new byte, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    logic [PB-1:0] fpos;
    logic [PB-1:0] hsize;
    assign fpos  = r_out_pos - PB'(r_gbytes) - PB'(1);
    assign hsize = r_out_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_la_cnt <= '0; r_in_pos <= '0; r_skip <= '0;
            r_flags <= '0; r_tok <= '0; r_gbytes <= '0; r_out_pos <= PB'(9);
            r_sum <= '0; r_wr <= '0; r_final <= 1'b0;
            r_fi <= '0; r_hi <= '0; r_may <= 1'b0;
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_final <= i_data.is_final;
                    if (r_la_cnt < LB'(MAX_MATCH)) begin
                        r_la[r_la_cnt] <= i_data.in_byte;
                        r_la_cnt <= r_la_cnt + LB'(1);
                    end
                end
                S_ADV: begin
                    if (r_la_cnt != '0 && (r_final || r_la_cnt >= LB'(MAX_MATCH))) begin
                        if (r_skip != '0) begin
                            r_wr <= wr_next;
                            for (int i = 0; i < MAX_MATCH - 1; i++) r_la[i] <= r_la[i+1];
                            r_la_cnt <= r_la_cnt - LB'(1);
                            if (r_in_pos != PMAX) r_in_pos <= r_in_pos + PB'(1);
                            r_skip <= r_skip - LB'(1);
                        end else begin
                            // start search
                            r_may <= !r_final || r_la_cnt > LB'(3);
                            r_off <= OB'(3); r_k <= '0; r_best <= LB'(2);
                            r_best_off <= '0;
                            r_maxoff <= (32'(r_in_pos) < 32'(WINDOW_SIZE)) ? OB'(r_in_pos)
                                                                          : OB'(WINDOW_SIZE);
                            if (r_in_pos >= PB'(MAX_MATCH - 1))
                                r_cap <= (r_la_cnt < LB'(MAX_MATCH)) ? r_la_cnt
                                                                     : LB'(MAX_MATCH);
                            else
                                r_cap <= (r_la_cnt < LB'(r_in_pos + PB'(1))) ? r_la_cnt
                                         : LB'(r_in_pos + PB'(1));
                        end
                    end else if (r_la_cnt == '0) begin
                        r_fi <= '0;
                    end
                end
                S_SRCH_CMP: begin
                    if (r_k < r_cap && r_la[r_k] == cand) begin
                        r_k <= r_k + LB'(1);
                    end else begin
                        if (r_k > r_best) begin r_best <= r_k; r_best_off <= r_off; end
                        r_k <= '0;
                        r_off <= r_off + OB'(1);
                    end
                end
                S_TOKEN: begin
                    if (r_best > LB'(2)) begin
                        r_flags <= r_flags | (8'h80 >> r_tok);
                        r_grp[r_gbytes[3:0]] <= {4'(r_best - LB'(3)),
                                                 4'(12'(r_best_off - OB'(1)) >> 8)};
                        r_grp[4'(r_gbytes + 5'd1)] <= 8'(r_best_off - OB'(1));
                        r_gbytes <= r_gbytes + 5'd2;
                        r_out_pos <= r_out_pos + PB'(2);
                        r_skip <= r_best - LB'(1);
                    end else begin
                        r_grp[r_gbytes[3:0]] <= r_la[0];
                        r_gbytes <= r_gbytes + 5'd1;
                        r_out_pos <= r_out_pos + PB'(1);
                        r_skip <= '0;
                    end
                    r_tok <= r_tok + 4'd1;
                    // the shift of this token's head byte
                    r_wr <= wr_next;
                    for (int i = 0; i < MAX_MATCH - 1; i++) r_la[i] <= r_la[i+1];
                    r_la_cnt <= r_la_cnt - LB'(1);
                    if (r_in_pos != PMAX) r_in_pos <= r_in_pos + PB'(1);
                    r_fi <= '0;
                end
                S_FLUSH: if (out_free) begin
                    r_oe <= 1'b0;
                    r_ob <= (r_fi == '0) ? r_flags : r_grp[4'(r_fi - 5'd1)];
                    r_op <= 21'(fpos + PB'(r_fi));
                    r_sum <= r_sum + 32'((r_fi == '0) ? r_flags : r_grp[4'(r_fi - 5'd1)]);
                    r_fi <= r_fi + 5'd1;
                    if (r_fi == r_gbytes) begin
                        r_flags <= '0; r_tok <= '0; r_gbytes <= '0;
                        // a full group reserves the next flag byte
                        if (r_tok == 4'd8) r_out_pos <= r_out_pos + PB'(1);
                    end
                end
                S_PAD: if (out_free) begin
                    if (r_out_pos[1:0] != 2'b00) begin
                        r_oe <= 1'b0; r_ob <= 8'h00;
                        r_op <= 21'(r_out_pos);
                        r_out_pos <= r_out_pos + PB'(1);
                    end else begin
                        r_hi <= '0;
                        r_cks <= 32'd0 - (r_sum + 32'(32'(hsize) >> 24)
                                 + 32'(8'(32'(hsize) >> 16)) + 32'(8'(32'(hsize) >> 8))
                                 + 32'(8'(hsize)));
                    end
                end
                S_HDR: if (out_free) begin
                    r_oe <= (r_hi == 4'd7);
                    r_op <= 21'(r_hi);
                    case (r_hi[2:0])
                        3'd0: r_ob <= r_cks[31:24];
                        3'd1: r_ob <= r_cks[23:16];
                        3'd2: r_ob <= r_cks[15:8];
                        3'd3: r_ob <= r_cks[7:0];
                        3'd4: r_ob <= 8'(32'(hsize) >> 24);
                        3'd5: r_ob <= 8'(32'(hsize) >> 16);
                        3'd6: r_ob <= 8'(32'(hsize) >> 8);
                        default: r_ob <= 8'(hsize);
                    endcase
                    r_hi <= r_hi + 4'd1;
                end
                S_RESET: begin
                    r_la_cnt <= '0; r_in_pos <= '0; r_skip <= '0; r_flags <= '0;
                    r_tok <= '0; r_gbytes <= '0; r_out_pos <= PB'(9); r_sum <= '0;
                    r_wr <= '0; r_final <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule
